@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, all sampled on clk and gated off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold whenever the block is out of reset.
`define STTK_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define STTK_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

@@ rtl/sttk_pkg.sv @@
// ----------------------------------------------------------------------------
// sttk_pkg
// Token codes, keyword table and shared types of the source text tokenizer.
// ----------------------------------------------------------------------------
package sttk_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int PREFIX_BYTES = 6;
  localparam int KW_COUNT     = 13;
  localparam int OUTQ_DEPTH   = 4;

  // token kinds
  localparam logic [5:0] KIND_IDENT   = 6'd13;
  localparam logic [5:0] KIND_NUMBER  = 6'd14;
  localparam logic [5:0] KIND_STRING  = 6'd15;
  localparam logic [5:0] KIND_OP_BASE = 6'd16;
  localparam logic [5:0] KIND_LSQR    = 6'd32;
  localparam logic [5:0] KIND_ERROR   = 6'd40;
  localparam logic [5:0] KIND_END     = 6'd41;

  // error causes
  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_BYTE   = 2'd1;
  localparam logic [1:0] CAUSE_STRING = 2'd2;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // keyword text, first byte in the low byte, zero padded
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h000000646E61,  // and
    48'h00000000726F,  // or
    48'h000000006669,  // if
    48'h000065736C65,  // else
    48'h00656C696877,  // while
    48'h000065757274,  // true
    48'h00006C6C756E,  // null
    48'h6E7275746572,  // return
    48'h00000074656C,  // let
    48'h0065736C6166,  // false
    48'h000000726F66,  // for
    48'h00746E697270,  // print
    48'h0000636F7270   // proc
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd4, 3'd4, 3'd6, 3'd3, 3'd5, 3'd3, 3'd5, 3'd4
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  cause;
    logic        last;
  } tok_t;

  // up to two tokens produced by one byte, oldest in t0
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  // exact full-length keyword match, else identifier
  function automatic logic [5:0] kw_kind(input logic [47:0] prefix,
                                         input logic [15:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (len == 16'(KW_LEN[k]) && prefix == KW_TEXT[k]) begin
        kind = 6'(k);
      end
    end
    return kind;
  endfunction

endpackage

@@ rtl/source_text_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming tokenizer: one source byte in, zero to two tokens out.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_ch
//   out_     out  out_valid / out_ready token_kind, token_start, token_length,
//                                       error_cause, last_of_run
//
// One byte per cycle while in_ready is high; the scanner decodes each byte
// combinationally and pushes its tokens into a four-entry result queue read out
// one per cycle while out_ready is high, so a token can leave on the cycle after
// its byte was taken. A byte that ends a pending token and is itself a bracket,
// a stray byte or the end marker yields two tokens and leaves the scanner idle,
// so two such bytes never come back to back; with out_ready high the queue
// holds at most two tokens and in_ready stays high.
// in_ready is low while the queue has fewer than two free entries, which
// happens only after out_ready stalls.
// Synchronous active-low reset clears scanner mode, offset and the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top #(
  parameter int POS_BITS = sttk_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [1:0]  out_error_cause,
  output logic        out_last_of_run
);

  logic            acc;
  sttk_pkg::push_t push;
  sttk_pkg::tok_t  head;

  assign acc = in_valid && in_ready;

  sttk_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_ch),
    .push  (push)
  );

  sttk_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (acc),
    .push    (push),
    .pop_rdy (out_ready),
    .pop_vld (out_valid),
    .head    (head),
    .room2   (in_ready)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_error_cause  = head.cause;
  assign out_last_of_run  = head.last;

endmodule

@@ rtl/sttk_outq.sv @@
// ----------------------------------------------------------------------------
// sttk_outq
// Result queue: takes up to two tokens per cycle, hands out one per cycle while pop_rdy is high.
// ----------------------------------------------------------------------------
module sttk_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_en,
  input  sttk_pkg::push_t push,
  input  logic            pop_rdy,
  output logic            pop_vld,
  output sttk_pkg::tok_t  head,
  output logic            room2
);

  localparam int AW = $clog2(sttk_pkg::OUTQ_DEPTH);

  sttk_pkg::tok_t mem_r [sttk_pkg::OUTQ_DEPTH];
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic [1:0]     pc;
  logic           pop;

  assign pc      = push_en ? push.n : 2'd0;
  assign pop_vld = (cnt_r != '0);
  assign pop     = pop_vld && pop_rdy;
  assign head    = mem_r[rd_r];
  assign room2   = (cnt_r <= (AW+1)'(sttk_pkg::OUTQ_DEPTH - 2));

  always_comb begin
    wr_nxt  = wr_r + AW'(pc);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(pc) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pc != 2'd0) begin
      mem_r[wr_r] <= push.t0;
    end
    if (pc == 2'd2) begin
      mem_r[wr_r + AW'(1)] <= push.t1;
    end
  end

endmodule

@@ rtl/sttk_scan.sv @@
// ----------------------------------------------------------------------------
// sttk_scan
// Scanner state and per-byte decode: yields zero, one or two tokens per byte.
// ----------------------------------------------------------------------------
module sttk_scan #(
  parameter int POS_BITS = sttk_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      ch,
  output sttk_pkg::push_t push
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_INT     = 3'd2;
  localparam logic [2:0] MODE_FRAC    = 3'd3;
  localparam logic [2:0] MODE_STRING  = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_OPER    = 3'd6;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  logic [2:0]          mode_r, mode_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [POS_BITS-1:0] cur_r, cur_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [47:0]         prefix_r, prefix_nxt;
  logic [2:0]          op_r, op_nxt;

  logic is_alpha, is_digit, is_space, is_word;
  logic op_hit, br_hit;
  logic [2:0] op_idx, br_idx;
  logic [15:0] len_inc, cur16, start16;
  logic fl_emit, id_emit, id_begin, use_fl, use_sec, brk;
  logic [2:0] id_mode;
  sttk_pkg::tok_t fl_tok, id_tok, sec_tok;

  // character classes
  always_comb begin
    is_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    is_digit = (ch >= 8'h30 && ch <= 8'h39);
    is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    is_word  = is_alpha || is_digit || (ch == CH_UNDER);
    op_hit = 1'b1;
    op_idx = 3'd0;
    case (ch)
      8'h2B:   op_idx = 3'd0;  // +
      8'h2D:   op_idx = 3'd1;  // -
      8'h2A:   op_idx = 3'd2;  // *
      8'h2F:   op_idx = 3'd3;  // /
      8'h3D:   op_idx = 3'd4;  // =
      8'h3C:   op_idx = 3'd5;  // <
      8'h3E:   op_idx = 3'd6;  // >
      8'h21:   op_idx = 3'd7;  // !
      default: op_hit = 1'b0;
    endcase
    br_hit = 1'b1;
    br_idx = 3'd0;
    case (ch)
      8'h5B:   br_idx = 3'd0;  // [
      8'h5D:   br_idx = 3'd1;  // ]
      8'h28:   br_idx = 3'd2;  // (
      8'h29:   br_idx = 3'd3;  // )
      8'h7B:   br_idx = 3'd4;  // {
      8'h7D:   br_idx = 3'd5;  // }
      8'h2C:   br_idx = 3'd6;  // comma
      8'h3B:   br_idx = 3'd7;  // semicolon
      default: br_hit = 1'b0;
    endcase
  end

  always_comb begin
    len_inc = (len_r == sttk_pkg::LEN_MAX) ? len_r : len_r + 16'd1;
    cur16   = 16'(cur_r);
    start16 = 16'(start_r);

    // pending token, ended by this byte
    fl_emit       = 1'b1;
    fl_tok.start  = start16;
    fl_tok.length = len_r;
    fl_tok.cause  = sttk_pkg::CAUSE_NONE;
    fl_tok.last   = 1'b0;
    fl_tok.kind   = sttk_pkg::KIND_NUMBER;
    case (mode_r)
      MODE_WORD:  fl_tok.kind = sttk_pkg::kw_kind(prefix_r, len_r);
      MODE_INT, MODE_FRAC: fl_tok.kind = sttk_pkg::KIND_NUMBER;
      MODE_STRING: begin
        fl_tok.kind  = sttk_pkg::KIND_ERROR;
        fl_tok.cause = sttk_pkg::CAUSE_STRING;
      end
      MODE_OPER:  fl_tok.kind = sttk_pkg::KIND_OP_BASE + {2'b00, op_r, 1'b0};
      default:    fl_emit = 1'b0;
    endcase

    // byte seen outside any token
    id_tok.kind   = br_hit ? sttk_pkg::KIND_LSQR + {3'b000, br_idx} : sttk_pkg::KIND_ERROR;
    id_tok.start  = cur16;
    id_tok.length = 16'd1;
    id_tok.cause  = br_hit ? sttk_pkg::CAUSE_NONE : sttk_pkg::CAUSE_BYTE;
    id_tok.last   = 1'b0;
    id_begin = 1'b0;
    id_emit  = 1'b0;
    if (is_space) begin
      id_mode = MODE_IDLE;
    end else if (ch == CH_HASH) begin
      id_mode = MODE_COMMENT;
    end else if (ch == CH_QUOTE) begin
      id_mode  = MODE_STRING;
      id_begin = 1'b1;
    end else if (is_alpha) begin
      id_mode  = MODE_WORD;
      id_begin = 1'b1;
    end else if (is_digit) begin
      id_mode  = MODE_INT;
      id_begin = 1'b1;
    end else if (op_hit) begin
      id_mode  = MODE_OPER;
      id_begin = 1'b1;
    end else begin
      id_mode = MODE_IDLE;
      id_emit = 1'b1;
    end

    mode_nxt   = mode_r;
    start_nxt  = start_r;
    cur_nxt    = cur_r + POS_BITS'(1);
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    op_nxt     = op_r;
    use_fl     = 1'b0;
    use_sec    = 1'b0;
    sec_tok    = id_tok;
    brk        = 1'b0;

    if (ch == CH_END) begin
      // flush, emit end, restart at offset zero
      use_fl         = fl_emit;
      use_sec        = 1'b1;
      sec_tok.kind   = sttk_pkg::KIND_END;
      sec_tok.start  = cur16;
      sec_tok.length = 16'd0;
      sec_tok.cause  = sttk_pkg::CAUSE_NONE;
      mode_nxt       = MODE_IDLE;
      cur_nxt        = '0;
      start_nxt      = '0;
      len_nxt        = '0;
      prefix_nxt     = '0;
      op_nxt         = '0;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          if (is_word) begin
            if (len_r < 16'(sttk_pkg::PREFIX_BYTES)) begin
              prefix_nxt = prefix_r | (48'(ch) << {len_r[2:0], 3'b000});
            end
            len_nxt = len_inc;
          end else begin
            brk = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            len_nxt = len_inc;
          end else if (ch == CH_DOT) begin
            len_nxt  = len_inc;
            mode_nxt = MODE_FRAC;
          end else begin
            brk = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            len_nxt = len_inc;
          end else begin
            brk = 1'b1;
          end
        end
        MODE_STRING: begin
          if (ch == CH_QUOTE) begin
            len_nxt        = len_inc;
            use_sec        = 1'b1;
            sec_tok.kind   = sttk_pkg::KIND_STRING;
            sec_tok.start  = start16;
            sec_tok.length = len_inc;
            sec_tok.cause  = sttk_pkg::CAUSE_NONE;
            mode_nxt       = MODE_IDLE;
          end else if (ch == CH_NL) begin
            // unterminated string; newline itself is dropped as whitespace
            use_fl   = 1'b1;
            mode_nxt = MODE_IDLE;
          end else begin
            len_nxt = len_inc;
          end
        end
        MODE_COMMENT: begin
          if (ch == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_OPER: begin
          if (ch == CH_EQ) begin
            len_nxt        = len_inc;
            use_sec        = 1'b1;
            sec_tok.kind   = sttk_pkg::KIND_OP_BASE + {2'b00, op_r, 1'b1};
            sec_tok.start  = start16;
            sec_tok.length = len_inc;
            sec_tok.cause  = sttk_pkg::CAUSE_NONE;
            mode_nxt       = MODE_IDLE;
          end else begin
            brk = 1'b1;
          end
        end
        default: brk = 1'b1;
      endcase

      if (brk) begin
        use_fl   = fl_emit;
        use_sec  = id_emit;
        mode_nxt = id_mode;
        if (id_begin) begin
          start_nxt  = cur_r;
          len_nxt    = 16'd1;
          prefix_nxt = 48'(ch);
          op_nxt     = op_idx;
        end
      end
    end

    // pack oldest first, mark the final one
    if (use_fl) begin
      push.t0 = fl_tok;
      push.t1 = sec_tok;
      push.n  = use_sec ? 2'd2 : 2'd1;
    end else begin
      push.t0 = sec_tok;
      push.t1 = sec_tok;
      push.n  = use_sec ? 2'd1 : 2'd0;
    end
    push.t0.last = (push.n == 2'd1);
    push.t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cur_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cur_r  <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      op_r     <= op_nxt;
    end
  end

endmodule

@@ rtl/sttk_chk.sv @@
// ----------------------------------------------------------------------------
// sttk_chk
// Port-level checks on the tokenizer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sttk_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic [1:0]  out_error_cause,
  input logic        out_last_of_run
);

  // stalled request holds
  `STTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_kind) && $stable(out_token_start) && $stable(out_token_length) && $stable(out_error_cause) && $stable(out_last_of_run), "result changed while stalled")

  // the second token of a byte is already queued behind the first
  `STTK_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_last_of_run, out_valid, "token run broken")

  `STTK_ASSERT_PROP(a_end_shape, out_valid && out_token_kind == sttk_pkg::KIND_END |-> out_token_length == 16'd0 && out_error_cause == sttk_pkg::CAUSE_NONE && out_last_of_run, "bad end token")

  `STTK_ASSERT_PROP(a_cause_err, out_valid && out_error_cause != sttk_pkg::CAUSE_NONE |-> out_token_kind == sttk_pkg::KIND_ERROR, "cause on non-error token")

endmodule

bind source_text_tokenizer_top sttk_chk u_sttk_chk (.*);
